// ----- rtl/ifir_pkg.sv -----
// Shared types and constants for the interpolating complex FIR.
// No dependencies; imported by every module of the block.
package ifir_pkg;

   localparam int SMP_W      = 16;
   localparam int PROD_W     = 2 * SMP_W;
   localparam int ACC_W      = 36;
   localparam int FACTOR_W   = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int NUM_PAIRS  = 4;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_UPSAMPLE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEFF_PAIR0 = 3'd1;

   // complex sample or tap: I in the high half, Q in the low half
   typedef struct packed {
      logic signed [SMP_W-1:0] i;
      logic signed [SMP_W-1:0] q;
   } cplx16_type;

   // complex partial sum, taken modulo 2^ACC_W
   typedef struct packed {
      logic [ACC_W-1:0] i;
      logic [ACC_W-1:0] q;
   } cplx36_type;

   // control that travels alongside each sample through the pipe
   typedef struct packed {
      logic valid;
      logic last;
   } ifir_tag_type;

endpackage

// ----- rtl/interpolating_complex_fir.sv -----
// Top level of the interpolating complex FIR: csr registers, sequencer,
// delay-line cell row and adder tree. Depends on ifir_pkg, ifir_seq,
// ifir_cell and ifir_sum_tree.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_sample_i, req_sample_q (16b signed)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_out_i, rsp_out_q (36b signed), rsp_last
//  csr     | in        | csr_we               | csr_addr (3b), csr_wdata (64b)
//
// Flow: one result per cycle while the pipe is not frozen by rsp_stall; a request
// yields max(1, min(upsample_factor, MAX_FACTOR)) samples, four at the reset factor.
// The next request is taken in the cycle the current one emits its last sample.
// From sequencer to rsp a sample passes the product register in the cells,
// then one register per tree level.
// Reset clears the delay line and all valid flags, and restores the factor (4)
// and the reset taps (a rectangular pulse on the newest taps).
// rsp_stall with a result waiting freezes the whole pipe; one request may
// still be taken into the sequencer while the pipe is frozen.
module interpolating_complex_fir
   import ifir_pkg::*;
#(
   parameter int TAPS       = 8,
   parameter int MAX_FACTOR = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [15:0]    req_sample_i,
   input  logic signed [15:0]    req_sample_q,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [35:0]    rsp_out_i,
   output logic signed [35:0]    rsp_out_q,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [FACTOR_W-1:0] factor_ff;
   cplx16_type          tap [TAPS];
   cplx16_type          link [1:TAPS];
   cplx16_type          seq_smp;
   cplx36_type          prod [TAPS];
   cplx36_type          root;
   ifir_tag_type        seq_tag, prod_tag_ff, out_tag;
   logic                adv, shift;

   // advance the whole pipe unless a result waits on a stalled rsp
   assign adv   = !(rsp_valid && rsp_stall);
   assign shift = adv && seq_tag.valid;

   // upsample factor register
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_W'(4);
      end else if (csr_we && csr_addr == CSR_UPSAMPLE) begin
         factor_ff <= csr_wdata[FACTOR_W-1:0];
      end
   end

   // tap registers; taps past the coefficient pairs keep their reset value
   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      localparam logic signed [SMP_W-1:0] RST_I =
         ((t + 4 >= TAPS) && (t >= 4)) ? SMP_W'(1) : SMP_W'(0);
      if (t < 2 * NUM_PAIRS) begin : g_reg
         localparam logic [CSR_ADDR_W-1:0] ADDR = CSR_COEFF_PAIR0 + CSR_ADDR_W'(t / 2);
         cplx16_type tap_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               tap_ff.i <= RST_I;
               tap_ff.q <= '0;
            end else if (csr_we && csr_addr == ADDR) begin
               // lower-numbered tap of a pair sits in the high word
               if (t % 2 == 0) begin
                  tap_ff <= csr_wdata[63:32];
               end else begin
                  tap_ff <= csr_wdata[31:0];
               end
            end
         end
         assign tap[t] = tap_ff;
      end else begin : g_const
         assign tap[t].i = RST_I;
         assign tap[t].q = '0;
      end
   end

   ifir_seq #(
      .MAX_FACTOR (MAX_FACTOR)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_i (req_sample_i),
      .req_sample_q (req_sample_q),
      .factor       (factor_ff),
      .adv          (adv),
      .smp          (seq_smp),
      .tag          (seq_tag)
   );

   // cell row: the newest sample enters the top cell, the oldest drops out of cell 0
   assign link[TAPS] = seq_smp;

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      if (k == 0) begin : g_oldest
         ifir_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .tap   (tap[k]),
            .din   (link[k+1]),
            .dout  (),
            .prod  (prod[k])
         );
      end else begin : g_mid
         ifir_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .tap   (tap[k]),
            .din   (link[k+1]),
            .dout  (link[k]),
            .prod  (prod[k])
         );
      end
   end

   // tag aligned with the product registers in the cells
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_tag_ff <= '0;
      end else if (adv) begin
         prod_tag_ff <= seq_tag;
      end
   end

   ifir_sum_tree #(
      .TAPS (TAPS)
   ) u_tree (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .prod    (prod),
      .tag_in  (prod_tag_ff),
      .root    (root),
      .tag_out (out_tag)
   );

   assign rsp_valid = out_tag.valid;
   assign rsp_last  = out_tag.last;
   assign rsp_out_i = root.i;
   assign rsp_out_q = root.q;

endmodule

// ----- rtl/ifir_seq.sv -----
// Zero-stuffing sequencer: holds one symbol and emits it followed by zeros.
// Depends on ifir_pkg.
module ifir_seq
   import ifir_pkg::*;
#(
   parameter int MAX_FACTOR = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_sample_i,
   input  logic signed [15:0]  req_sample_q,
   input  logic [FACTOR_W-1:0] factor,
   input  logic                adv,
   output cplx16_type          smp,
   output ifir_tag_type        tag
);

   localparam int IDX_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
   localparam int FX_W  = FACTOR_W + 2;
   localparam logic [FX_W-1:0] MAXF = FX_W'(MAX_FACTOR);

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   cplx16_type       sym_ff, sym_in;
   logic [FX_W-1:0]  f_ext, f_eff;
   logic [IDX_W-1:0] last_idx;
   logic             at_last, emit, take;

   // clamp the factor: zero acts as one, large values saturate
   always_comb begin
      f_ext = {2'b00, factor};
      if (factor == '0) begin
         f_eff = FX_W'(1);
      end else if (f_ext > MAXF) begin
         f_eff = MAXF;
      end else begin
         f_eff = f_ext;
      end
   end

   assign last_idx  = IDX_W'(f_eff - FX_W'(1));
   assign at_last   = (idx_ff == last_idx);
   assign emit      = busy_ff && adv;
   assign req_stall = busy_ff && !(adv && at_last);
   assign take      = req_valid && !req_stall;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      sym_in  = sym_ff;
      if (emit) begin
         if (at_last) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = IDX_W'(idx_ff + 1'b1);
         end
      end
      if (take) begin
         busy_in  = 1'b1;
         sym_in.i = req_sample_i;
         sym_in.q = req_sample_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      sym_ff <= sym_in;
   end

   assign smp       = (idx_ff == '0) ? sym_ff : '0;
   assign tag.valid = busy_ff;
   assign tag.last  = at_last;

endmodule

// ----- rtl/ifir_cell.sv -----
// One delay-line cell: holds one window sample and registers its tap product.
// Depends on ifir_pkg.
module ifir_cell
   import ifir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift,
   input  cplx16_type tap,
   input  cplx16_type din,
   output cplx16_type dout,
   output cplx36_type prod
);

   cplx16_type               w_ff;
   cplx36_type               prod_ff, prod_in;
   logic signed [PROD_W-1:0] ii, qq, iq, qi;

   assign ii = $signed(din.i) * $signed(tap.i);
   assign qq = $signed(din.q) * $signed(tap.q);
   assign iq = $signed(din.i) * $signed(tap.q);
   assign qi = $signed(din.q) * $signed(tap.i);

   // product of the sample that enters this cell on the shift
   always_comb begin
      prod_in.i = {{(ACC_W-PROD_W){ii[PROD_W-1]}}, ii}
                - {{(ACC_W-PROD_W){qq[PROD_W-1]}}, qq};
      prod_in.q = {{(ACC_W-PROD_W){iq[PROD_W-1]}}, iq}
                + {{(ACC_W-PROD_W){qi[PROD_W-1]}}, qi};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else if (shift) begin
         w_ff <= din;
      end
      if (shift) begin
         prod_ff <= prod_in;
      end
   end

   assign dout = w_ff;
   assign prod = prod_ff;

endmodule

// ----- rtl/ifir_sum_tree.sv -----
// Registered binary adder tree over the cell products, with its tag pipe.
// Depends on ifir_pkg.
module ifir_sum_tree
   import ifir_pkg::*;
#(
   parameter int TAPS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  cplx36_type   prod [TAPS],
   input  ifir_tag_type tag_in,
   output cplx36_type   root,
   output ifir_tag_type tag_out
);

   localparam int LEVELS = (TAPS > 1) ? $clog2(TAPS) : 0;
   localparam int LEAVES = 1 << LEVELS;

   // heap order: node 1 is the root, leaves sit at LEAVES..2*LEAVES-1
   cplx36_type node [1:2*LEAVES-1];

   for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < TAPS) begin : g_used
         assign node[LEAVES+k] = prod[k];
      end else begin : g_pad
         assign node[LEAVES+k] = '0;
      end
   end

   for (genvar n = 1; n < LEAVES; n++) begin : g_node
      always_ff @(posedge clock) begin
         if (adv) begin
            node[n].i <= node[2*n].i + node[2*n+1].i;
            node[n].q <= node[2*n].q + node[2*n+1].q;
         end
      end
   end

   if (LEVELS == 0) begin : g_flat
      assign tag_out = tag_in;
   end else begin : g_tags
      ifir_tag_type tag_ff [1:LEVELS];
      always_ff @(posedge clock) begin
         if (reset) begin
            for (int l = 1; l <= LEVELS; l++) begin
               tag_ff[l] <= '0;
            end
         end else if (adv) begin
            tag_ff[1] <= tag_in;
            for (int l = 2; l <= LEVELS; l++) begin
               tag_ff[l] <= tag_ff[l-1];
            end
         end
      end
      assign tag_out = tag_ff[LEVELS];
   end

   assign root = node[1];

endmodule

// ----- tb/sv/ifir_shape_checker.sv -----
`timescale 1ns / 1ps
// Checker for the interpolating complex FIR: mirrors the csr registers, predicts
// every shaped output sample and compares the rsp channel against the prediction.
// Depends on ifir_pkg.
module ifir_shape_checker
   import ifir_pkg::*;
#(
   parameter int TAPS       = 8,
   parameter int MAX_FACTOR = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic signed [15:0]    req_sample_i,
   input  logic signed [15:0]    req_sample_q,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic signed [35:0]    rsp_out_i,
   input  logic signed [35:0]    rsp_out_q,
   input  logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    samples_owed
);

   localparam int RESET_FACTOR = 4;

   typedef struct {
      logic signed [ACC_W-1:0] i;
      logic signed [ACC_W-1:0] q;
      logic                    last;
   } shaped_type;

   shaped_type              shaped_q [$];
   logic signed [SMP_W-1:0] hist_i [TAPS];
   logic signed [SMP_W-1:0] hist_q [TAPS];
   logic signed [SMP_W-1:0] tap_i [TAPS];
   logic signed [SMP_W-1:0] tap_q [TAPS];
   logic [FACTOR_W-1:0]     factor;
   int                      errors = 0;

   // rectangular pulse on the newest taps (index at least 4 and TAPS-4), empty history
   function automatic void load_defaults();
      for (int k = 0; k < TAPS; k++) begin
         hist_i[k] = '0;
         hist_q[k] = '0;
         tap_i[k]  = (k >= 4 && k + 4 >= TAPS) ? 16'sd1 : 16'sd0;
         tap_q[k]  = '0;
      end
      factor = FACTOR_W'(RESET_FACTOR);
   endfunction

   function automatic void load_tap(int idx, logic [31:0] word);
      if (idx < TAPS) begin
         tap_i[idx] = word[31:16];
         tap_q[idx] = word[15:0];
      end
   endfunction

   // zero-stuff one symbol and push every filtered sample it yields
   function automatic void shape_symbol(logic signed [SMP_W-1:0] sym_i,
                                        logic signed [SMP_W-1:0] sym_q);
      int         n;
      longint     acc_i;
      longint     acc_q;
      shaped_type r;
      n = (factor == 0) ? 1 : (factor > MAX_FACTOR) ? MAX_FACTOR : int'(factor);
      for (int s = 0; s < n; s++) begin
         for (int k = 0; k < TAPS - 1; k++) begin
            hist_i[k] = hist_i[k + 1];
            hist_q[k] = hist_q[k + 1];
         end
         hist_i[TAPS - 1] = (s == 0) ? sym_i : '0;
         hist_q[TAPS - 1] = (s == 0) ? sym_q : '0;
         acc_i = 0;
         acc_q = 0;
         for (int j = 0; j < TAPS; j++) begin
            acc_i += longint'(hist_i[j]) * longint'(tap_i[j])
                   - longint'(hist_q[j]) * longint'(tap_q[j]);
            acc_q += longint'(hist_i[j]) * longint'(tap_q[j])
                   + longint'(hist_q[j]) * longint'(tap_i[j]);
         end
         r.i    = acc_i[ACC_W-1:0];
         r.q    = acc_q[ACC_W-1:0];
         r.last = (s == n - 1);
         shaped_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      shaped_type want;
      int         pair;
      if (reset) begin
         load_defaults();
         shaped_q.delete();
      end else begin
         if (csr_we) begin
            pair = int'(csr_addr) - int'(CSR_COEFF_PAIR0);
            if (csr_addr == CSR_UPSAMPLE) begin
               factor = csr_wdata[FACTOR_W-1:0];
            end else if (pair >= 0 && pair < NUM_PAIRS) begin
               load_tap(2 * pair, csr_wdata[63:32]);
               load_tap(2 * pair + 1, csr_wdata[31:0]);
            end
         end
         if (req_valid && !req_stall) begin
            shape_symbol(req_sample_i, req_sample_q);
         end
         if (rsp_valid && !rsp_stall) begin
            if (shaped_q.size() == 0) begin
               $display("%0t: result with nothing pending: i=%0d q=%0d last=%0b",
                        $time, rsp_out_i, rsp_out_q, rsp_last);
               errors++;
            end else begin
               want = shaped_q.pop_front();
               if (rsp_out_i !== want.i) begin
                  $display("%0t: out_i expected %0d got %0d", $time, want.i, rsp_out_i);
                  errors++;
               end
               if (rsp_out_q !== want.q) begin
                  $display("%0t: out_q expected %0d got %0d", $time, want.q, rsp_out_q);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b got %0b", $time, want.last, rsp_last);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      samples_owed   <= shaped_q.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the interpolating complex FIR testbench: clock, reset, request and
// csr stimulus, receiver stalls and verdict. Depends on ifir_pkg,
// interpolating_complex_fir and ifir_shape_checker.
module testbench;
   import ifir_pkg::*;

   localparam int TAPS               = 8;
   localparam int MAX_FACTOR         = 16;
   localparam int PERIOD             = 20;
   localparam int RESET_CYCLES       = 10;
   // sequencer to rsp passes the cell product register and the tree levels; leave a margin on top
   localparam int SETTLE_CYCLES      = 12;
   localparam int LONG_HOLD          = 300;
   localparam int PHASES             = 3;
   localparam int SETTINGS_PER_PHASE = 3;
   localparam int ITEMS_PER_SETTING  = 18;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = CSR_COEFF_PAIR0 + CSR_ADDR_W'(NUM_PAIRS);
   localparam logic [CSR_DATA_W-1:0] PAIR_MAX  = 64'h7FFF_7FFF_7FFF_7FFF;
   localparam logic [CSR_DATA_W-1:0] PAIR_MIN  = 64'h8000_8000_8000_8000;
   localparam logic [CSR_DATA_W-1:0] PAIR_SKEW = 64'h8000_7FFF_7FFF_8000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_sample_i = '0;
   logic signed [15:0]    req_sample_q = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [35:0]    rsp_out_i;
   logic signed [35:0]    rsp_out_q;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int   mismatch_count;
   int   samples_owed;
   int   send_pct = 0;      // chance in percent that the sender idles a cycle
   int   stall_pct = 0;     // chance in percent that the receiver stalls a cycle
   logic hold_trigger = 1'b0;
   int   hold_left = 0;

   interpolating_complex_fir #(
      .TAPS       (TAPS),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_i (req_sample_i),
      .req_sample_q (req_sample_q),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_i    (rsp_out_i),
      .rsp_out_q    (rsp_out_q),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   ifir_shape_checker #(
      .TAPS       (TAPS),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_i      (rsp_out_i),
      .rsp_out_q      (rsp_out_q),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .samples_owed   (samples_owed)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Receiver: random stalls, except during a long hold. The hold is counted
   // here so the sender can keep offering requests while the pipe backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_trigger) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Mostly random samples, with the corners of the range mixed in often.
   function automatic logic [SMP_W-1:0] pick_sample();
      case ($urandom_range(11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one request and hold it until taken. Valid stays high on return so
   // back-to-back requests never see valid dropped and raised in one step.
   task automatic send_symbol(logic [SMP_W-1:0] sym_i, logic [SMP_W-1:0] sym_q);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_i <= sym_i;
      req_sample_q <= sym_q;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted sample has come out, then wait out
   // the settle margin so the pipe goes fully quiet.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      do @(posedge clock); while (samples_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write enable stays high across consecutive writes; the caller drops it.
   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Program factor and all four tap pairs; junk lands in the unused factor bits
   // and, when asked, a write to an index past the last pair must be ignored.
   task automatic apply_setting(logic [FACTOR_W-1:0] f, logic [CSR_DATA_W-1:0] p0,
                                logic [CSR_DATA_W-1:0] p1, logic [CSR_DATA_W-1:0] p2,
                                logic [CSR_DATA_W-1:0] p3, bit spare);
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] pairs [NUM_PAIRS];
      w              = {$urandom, $urandom};
      w[FACTOR_W-1:0] = f;
      pairs[0]       = p0;
      pairs[1]       = p1;
      pairs[2]       = p2;
      pairs[3]       = p3;
      write_csr(CSR_UPSAMPLE, w);
      for (int k = 0; k < NUM_PAIRS; k++) begin
         write_csr(CSR_COEFF_PAIR0 + CSR_ADDR_W'(k), pairs[k]);
      end
      if (spare) begin
         write_csr(CSR_SPARE, '1);
      end
      csr_we <= 1'b0;
   endtask

   // Small factors most of the time, the whole 5-bit field now and then.
   task automatic random_setting();
      logic [FACTOR_W-1:0] f;
      if ($urandom_range(3) != 0) begin
         f = FACTOR_W'($urandom_range(1, 4));
      end else begin
         f = FACTOR_W'($urandom_range(0, 31));
      end
      apply_setting(f, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(3) == 0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_pct = 23;
      stall_pct <= 57;

      // Reset taps (rectangular pulse) and reset factor: corner samples.
      send_symbol(16'h0000, 16'h0000);
      send_symbol(16'h7FFF, 16'h7FFF);
      send_symbol(16'h8000, 16'h8000);
      send_symbol(16'h7FFF, 16'h8000);
      send_symbol(16'h8000, 16'h7FFF);
      send_symbol(16'h0001, 16'hFFFF);

      // Factor zero acts as one; largest positive taps; stray index write.
      drain_pipe();
      apply_setting(5'd0, PAIR_MAX, PAIR_MAX, PAIR_MAX, PAIR_MAX, 1'b1);
      send_symbol(16'h8000, 16'h8000);
      send_symbol(16'h7FFF, 16'h7FFF);
      send_symbol(16'h8000, 16'h7FFF);

      // Factor at the top of the field clamps to the maximum; most negative taps.
      drain_pipe();
      apply_setting(5'd31, PAIR_MIN, PAIR_MIN, PAIR_MIN, PAIR_MIN, 1'b0);
      send_symbol(16'h8000, 16'h8000);
      send_symbol(16'h7FFF, 16'h8000);
      send_symbol(16'h7FFF, 16'h7FFF);

      // Factor one, taps with I and Q at opposite corners.
      drain_pipe();
      apply_setting(5'd1, PAIR_SKEW, PAIR_SKEW, PAIR_SKEW, PAIR_SKEW, 1'b0);
      send_symbol(16'h8000, 16'h7FFF);
      send_symbol(16'h7FFF, 16'h8000);
      send_symbol(16'h8000, 16'h8000);

      // Factor exactly at the maximum, then just past it.
      drain_pipe();
      apply_setting(FACTOR_W'(MAX_FACTOR), {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      send_symbol(pick_sample(), pick_sample());
      send_symbol(pick_sample(), pick_sample());
      drain_pipe();
      apply_setting(FACTOR_W'(MAX_FACTOR + 1), {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      send_symbol(pick_sample(), pick_sample());
      send_symbol(pick_sample(), pick_sample());

      // Random part: receiver-heavy stalling, then sender-heavy idling, then none.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_pct = 23;
               stall_pct <= 57;
            end
            1: begin
               send_pct = 57;
               stall_pct <= 23;
            end
            default: begin
               send_pct = 0;
               stall_pct <= 0;
            end
         endcase
         for (int setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
            drain_pipe();
            random_setting();
            // Hold the receiver off while requests keep coming so the pipe
            // fills and the block has to stall its input.
            if (phase == PHASES - 1 && setting == 0) begin
               hold_trigger <= 1'b1;
               @(posedge clock);
               hold_trigger <= 1'b0;
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
               send_symbol(pick_sample(), pick_sample());
            end
         end
      end

      drain_pipe();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
